[design/bfld_pkg.sv]
// shared types and constants for the block-framed lzss decoder
// no dependencies; used by bfld_ring and block_framed_lzss_decoder_top
package bfld_pkg;

    localparam int RING_SIZE = 4096;
    localparam int RING_AW   = 12;

    localparam logic [4:0] MATCH_MAX = 5'd18;
    localparam logic [4:0] MIN_MATCH = 5'd3;

    // write position after a ring restart
    localparam logic [RING_AW-1:0] RING_START = RING_AW'(RING_SIZE - int'(MATCH_MAX));

    localparam logic [7:0] BYTE_SPACE = 8'h20;

    // request from the sequencer to the ring store
    typedef struct packed {
        logic               clear;
        logic               wr_en;
        logic [7:0]         wr_data;
        logic               rd_en;
        logic [RING_AW-1:0] rd_addr;
    } t_ring_req;

endpackage

[design/bfld_ring.sv]
// 4096-byte history ring with its own write pointer and fill count
// depends on bfld_pkg; entries not written since the last restart read as spaces
module bfld_ring (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bfld_pkg::t_ring_req i_req,
    output logic [7:0]          o_rd_data
);
    import bfld_pkg::*;

    logic [7:0]         mem [RING_SIZE];
    logic [RING_AW-1:0] r_wr_pos;
    logic [RING_AW:0]   r_fill;
    logic [7:0]         r_rd_byte;
    logic               r_rd_hit;
    logic [RING_AW-1:0] w_rd_off;

    // writes run upward from the start position, so written entries form one range
    assign w_rd_off = i_req.rd_addr - RING_START;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[r_wr_pos] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_byte <= mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos <= RING_START;
            r_fill   <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_wr_pos <= RING_START;
                r_fill   <= '0;
            end else if (i_req.wr_en) begin
                r_wr_pos <= r_wr_pos + 1'b1;
                if (r_fill != (RING_AW+1)'(RING_SIZE)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_req.rd_en) begin
                r_rd_hit <= ({1'b0, w_rd_off} < r_fill);
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_byte : BYTE_SPACE;

endmodule

[design/block_framed_lzss_decoder_top.sv]
// top level of the block-framed lzss decoder: frame parser, copy sequencer, output register
// depends on bfld_pkg and bfld_ring
//
//  channel   direction  handshake                  word contents
//  -------   ---------  -------------------------  ---------------------------------------
//  in        sink       i_in_valid / o_in_ready    i_in_byte
//  out       source     o_out_valid / i_out_ready  o_out_byte, o_last_of_run, o_end_of_stream
//  cfg       sink       i_cfg_we (no wait)         i_cfg_data = output_length
//
//  sequencing: a header, flag or match first word is taken in idle; a literal or raw word
//    goes through the literal state; each copied byte of a match is one ring read followed
//    by one ring write through the single ring port pair
//  reset: synchronous, active low; the ring restarts through its fill count, no clearing pass
//  stalls: the output register holds a word until taken; the sequencer waits on it and
//    o_in_ready stays low until every word of the current input word is in the register
module block_framed_lzss_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_end_of_stream,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    import bfld_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR_HI,
        PH_HDR_LO,
        PH_RAW,
        PH_ITEM_START,
        PH_ITEM_BODY,
        PH_MATCH_SECOND
    } t_phase;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIT,
        S_CP_RD,
        S_CP_WR
    } t_state;

    t_state             r_state;
    t_phase             r_phase;
    logic [7:0]         r_hdr_hi;
    logic [14:0]        r_remain;
    logic [8:0]         r_flags;
    logic [7:0]         r_match_lo;
    logic [31:0]        r_count;
    logic [31:0]        r_out_len;
    logic [7:0]         r_lit_byte;
    logic               r_lit_ring;
    logic               r_blk_done;
    logic [RING_AW-1:0] r_cp_pos;
    logic [4:0]         r_cp_left;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;
    logic               r_out_eos;

    logic        w_acc;
    logic [15:0] w_word;
    logic [14:0] w_rem_dec;
    logic        w_rem_zero;
    logic [8:0]  w_fs;
    logic        w_need_flag;
    logic        w_item_go;
    logic [7:0]  w_item_x;
    logic        w_item_lit;
    logic [8:0]  w_new_flags;
    logic        w_out_load;
    logic        w_out_push;
    logic [31:0] w_cnt_inc;
    logic        w_ends;
    logic        w_cp_final;
    logic [7:0]  w_rd_data;
    t_ring_req   w_ring_req;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    // header word and block length countdown
    assign w_word     = {r_hdr_hi, i_in_byte};
    assign w_rem_dec  = r_remain - 1'b1;
    assign w_rem_zero = (w_rem_dec == '0);

    // flags shift out lsb first under a marker bit
    assign w_fs        = {1'b0, r_flags[8:1]};
    assign w_need_flag = (w_fs[8:1] == '0);

    // first byte of an item: literal, or first half of a match
    always_comb begin
        w_item_go   = 1'b0;
        w_item_x    = i_in_byte;
        w_item_lit  = 1'b0;
        w_new_flags = r_flags;
        case (r_phase)
            PH_ITEM_START: begin
                if (w_need_flag) begin
                    w_new_flags = {1'b1, i_in_byte};
                    // lone flag at block end: the item byte is taken as zero
                    if (w_rem_zero) begin
                        w_item_go  = 1'b1;
                        w_item_x   = 8'h00;
                        w_item_lit = i_in_byte[0];
                    end
                end else begin
                    w_new_flags = w_fs;
                    w_item_go   = 1'b1;
                    w_item_lit  = w_fs[0];
                end
            end
            PH_ITEM_BODY: begin
                w_item_go  = 1'b1;
                w_item_lit = r_flags[0];
            end
            default: begin
            end
        endcase
    end

    // output register takes a new word when empty or being drained
    assign w_out_load = !r_out_valid || i_out_ready;
    assign w_out_push = w_out_load && (r_state == S_LIT || r_state == S_CP_WR);

    // saturating emitted count, stream end checked on the block's last word
    assign w_cnt_inc  = (r_count == '1) ? r_count : r_count + 1'b1;
    assign w_ends     = r_blk_done && (w_cnt_inc >= r_out_len);
    assign w_cp_final = (r_cp_left == 5'd1);

    always_comb begin
        w_ring_req.clear   = w_acc && (r_phase == PH_HDR_LO) && !w_word[15];
        w_ring_req.wr_en   = w_out_load &&
                             ((r_state == S_LIT && r_lit_ring) || r_state == S_CP_WR);
        w_ring_req.wr_data = (r_state == S_LIT) ? r_lit_byte : w_rd_data;
        w_ring_req.rd_en   = (r_state == S_CP_RD);
        w_ring_req.rd_addr = r_cp_pos;
    end

    bfld_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_ring_req),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_HDR_HI;
            r_hdr_hi    <= '0;
            r_remain    <= '0;
            r_flags     <= '0;
            r_match_lo  <= '0;
            r_count     <= '0;
            r_out_len   <= 32'd1;
            r_lit_ring  <= 1'b0;
            r_blk_done  <= 1'b0;
            r_cp_left   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_out_len <= i_cfg_data;
            end
            // a new word refills the register, otherwise a taken word empties it
            if (w_out_push) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (r_phase)
                            PH_HDR_HI: begin
                                r_hdr_hi <= i_in_byte;
                                r_phase  <= PH_HDR_LO;
                            end
                            PH_HDR_LO: begin
                                r_remain <= w_word[14:0];
                                if (!w_word[15]) begin
                                    r_flags <= '0;
                                end
                                if (w_word[14:0] == '0) begin
                                    // empty block ends with no word, so a stream end is silent
                                    r_phase <= PH_HDR_HI;
                                    if (r_count >= r_out_len) begin
                                        r_count <= '0;
                                    end
                                end else if (w_word[15]) begin
                                    r_phase <= PH_RAW;
                                end else begin
                                    r_phase <= PH_ITEM_START;
                                end
                            end
                            PH_RAW: begin
                                r_remain   <= w_rem_dec;
                                r_lit_byte <= i_in_byte;
                                r_lit_ring <= 1'b0;
                                r_blk_done <= w_rem_zero;
                                r_state    <= S_LIT;
                                if (w_rem_zero) begin
                                    r_phase <= PH_HDR_HI;
                                end
                            end
                            PH_ITEM_START, PH_ITEM_BODY: begin
                                r_remain <= w_rem_dec;
                                r_flags  <= w_new_flags;
                                if (!w_item_go) begin
                                    r_phase <= PH_ITEM_BODY;
                                end else if (w_item_lit) begin
                                    r_lit_byte <= w_item_x;
                                    r_lit_ring <= 1'b1;
                                    r_blk_done <= w_rem_zero;
                                    r_state    <= S_LIT;
                                    r_phase    <= w_rem_zero ? PH_HDR_HI : PH_ITEM_START;
                                end else if (w_rem_zero) begin
                                    // match cut short: shortest copy from the given position
                                    r_cp_pos   <= RING_AW'(w_item_x);
                                    r_cp_left  <= MIN_MATCH;
                                    r_blk_done <= 1'b1;
                                    r_state    <= S_CP_RD;
                                    r_phase    <= PH_HDR_HI;
                                end else begin
                                    r_match_lo <= w_item_x;
                                    r_phase    <= PH_MATCH_SECOND;
                                end
                            end
                            PH_MATCH_SECOND: begin
                                r_remain   <= w_rem_dec;
                                r_cp_pos   <= {i_in_byte[7:4], r_match_lo};
                                r_cp_left  <= 5'(i_in_byte[3:0]) + MIN_MATCH;
                                r_blk_done <= w_rem_zero;
                                r_state    <= S_CP_RD;
                                r_phase    <= w_rem_zero ? PH_HDR_HI : PH_ITEM_START;
                            end
                            default: begin
                                r_phase <= PH_HDR_HI;
                            end
                        endcase
                    end
                end
                S_LIT: begin
                    if (w_out_load) begin
                        r_out_byte  <= r_lit_byte;
                        r_out_last  <= 1'b1;
                        r_out_eos   <= w_ends;
                        r_count     <= w_ends ? '0 : w_cnt_inc;
                        r_state     <= S_IDLE;
                    end
                end
                S_CP_RD: begin
                    r_state <= S_CP_WR;
                end
                S_CP_WR: begin
                    if (w_out_load) begin
                        r_out_byte  <= w_rd_data;
                        r_out_last  <= w_cp_final;
                        r_out_eos   <= w_cp_final && w_ends;
                        r_count     <= (w_cp_final && w_ends) ? '0 : w_cnt_inc;
                        r_cp_pos    <= r_cp_pos + 1'b1;
                        r_cp_left   <= r_cp_left - 1'b1;
                        r_state     <= w_cp_final ? S_IDLE : S_CP_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_last_of_run   = r_out_last;
    assign o_end_of_stream = r_out_eos;

    // copy length stays within the match range while copying
    a_cp_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CP_RD || r_state == S_CP_WR) |->
            (r_cp_left != '0 && r_cp_left <= MATCH_MAX))
        else $error("copy count out of range");

    // a match's second byte always starts a copy
    a_match_starts_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase == PH_MATCH_SECOND) |=> (r_state == S_CP_RD))
        else $error("match did not start copy");

    // stream end only rides on the final word of an input word
    a_eos_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_eos) |-> r_out_last)
        else $error("end of stream without last");

    // an empty block goes straight back to header parsing with no word
    a_empty_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && r_phase == PH_HDR_LO && w_word[14:0] == '0) |=>
            (r_phase == PH_HDR_HI && r_state == S_IDLE))
        else $error("empty block not closed");

endmodule

[bench/block_framed_lzss_decoder_top_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for block_framed_lzss_decoder_top: directed frames, then random block streams
// depends on bfld_pkg and the decoder rtl; predicts every decoded word from its own decoder copy
module block_framed_lzss_decoder_top_tb;
    import bfld_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 64;
    localparam int PHASE_ITEMS   = 48;
    localparam int REPORT_LIMIT  = 100;

    // parser position inside the framed stream
    typedef enum logic [2:0] {
        HDR_HI,
        HDR_LO,
        RAW_BODY,
        ITEM_START,
        ITEM_BODY,
        MATCH_SECOND
    } t_parse_phase;

    // receiver back-pressure styles
    typedef enum logic [1:0] {
        SINK_FREE,
        SINK_MOSTLY,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_mode;

    // one decoded word as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eos;
    } t_out_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic        o_end_of_stream;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = 32'd0;

    block_framed_lzss_decoder_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_in_byte       (i_in_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_stream (o_end_of_stream),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder copy: ring, parser and stream counters
    // ------------------------------------------------------------------
    logic [7:0]         ring_m [0:RING_SIZE-1];
    logic [RING_AW-1:0] wpos_m;
    logic [8:0]         flags_m;        // unused flags under a marker bit
    t_parse_phase       phase_m;
    logic [14:0]        remaining_m;
    logic               raw_m;
    logic [7:0]         hdr_hi_m;
    logic [7:0]         match_lo_m;
    logic [31:0]        count_m;        // decoded bytes in the current stream
    logic [31:0]        out_len_m;      // output_length as last written

    t_out_word expected_words [$];
    t_out_word cur_run [$];             // words caused by the word being decoded
    logic      block_end;

    logic [7:0] pending_bytes [$];      // stimulus not yet offered

    int fail_count    = 0;
    int words_checked = 0;
    int items_taken   = 0;
    int eos_seen      = 0;
    int raw_blocks    = 0;
    int packed_blocks = 0;
    int cycle_count   = 0;

    task automatic restart_ring();
        foreach (ring_m[i])
            ring_m[i] = BYTE_SPACE;
        wpos_m  = RING_START;
        flags_m = '0;
    endtask

    task automatic emit_word(input logic [7:0] b);
        t_out_word w;
        w.data = b;
        w.last = 1'b0;
        w.eos  = 1'b0;
        if (cur_run.size() < int'(MATCH_MAX))
            cur_run.push_back(w);
        if (count_m != 32'hFFFF_FFFF)
            count_m++;
    endtask

    task automatic emit_ring(input logic [7:0] b);
        emit_word(b);
        ring_m[wpos_m] = b;
        wpos_m++;
    endtask

    task automatic copy_run(input logic [11:0] pos, input logic [3:0] len_field);
        int n;
        n = int'(len_field) + int'(MIN_MATCH);
        for (int k = 0; k < n; k++)
            emit_ring(ring_m[pos + 12'(k)]);
    endtask

    task automatic end_or_next();
        if (remaining_m == 0)
            block_end = 1'b1;
        else
            phase_m = ITEM_START;
    endtask

    // first byte of an item; the block count is already taken down
    task automatic item_first(input logic [7:0] b);
        if (flags_m[0]) begin
            emit_ring(b);
            end_or_next();
        end else if (remaining_m == 0) begin
            copy_run({4'h0, b}, 4'h0);
            block_end = 1'b1;
        end else begin
            match_lo_m = b;
            phase_m    = MATCH_SECOND;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic ended;
        ended     = 1'b0;
        block_end = 1'b0;
        cur_run.delete();
        case (phase_m)
            HDR_HI: begin
                hdr_hi_m = b;
                phase_m  = HDR_LO;
            end
            HDR_LO: begin
                remaining_m = {hdr_hi_m[6:0], b};
                raw_m       = hdr_hi_m[7];
                if (!raw_m)
                    restart_ring();
                if (remaining_m == 0)
                    block_end = 1'b1;
                else
                    phase_m = raw_m ? RAW_BODY : ITEM_START;
            end
            RAW_BODY: begin
                remaining_m--;
                emit_word(b);
                if (remaining_m == 0)
                    block_end = 1'b1;
            end
            ITEM_START: begin
                remaining_m--;
                flags_m = flags_m >> 1;
                if (flags_m[8:1] == 0) begin
                    flags_m = {1'b1, b};
                    if (remaining_m == 0)
                        item_first(8'h00);    // lone flag byte, item bytes read as zero
                    else
                        phase_m = ITEM_BODY;
                end else begin
                    item_first(b);
                end
            end
            ITEM_BODY: begin
                remaining_m--;
                item_first(b);
            end
            MATCH_SECOND: begin
                remaining_m--;
                copy_run({b[7:4], match_lo_m}, b[3:0]);
                end_or_next();
            end
            default: phase_m = HDR_HI;
        endcase
        if (block_end) begin
            phase_m = HDR_HI;
            if (count_m >= out_len_m) begin
                ended   = 1'b1;
                count_m = '0;
            end
        end
        if (cur_run.size() > 0) begin
            cur_run[cur_run.size()-1].last = 1'b1;
            cur_run[cur_run.size()-1].eos  = ended;
        end
        foreach (cur_run[i])
            expected_words.push_back(cur_run[i]);
    endtask

    // ------------------------------------------------------------------
    // input side: acceptance at the rising edge, next word at the falling edge
    // ------------------------------------------------------------------
    logic in_accepted = 1'b0;
    int   burst_left  = 1;
    int   gap_left    = 0;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            decode_byte(i_in_byte);
            in_accepted = 1'b1;
            items_taken++;
        end
    end

    // bursts of random length with random gaps; some gaps are zero for back-to-back runs
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_accepted) begin
            in_accepted = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                i_in_byte  <= pending_bytes.pop_front();
                i_in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: stall pattern at the falling edge, checks at the rising edge
    // ------------------------------------------------------------------
    t_sink_mode sink_mode = SINK_FREE;
    int         mode_left = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            // long hold-off: the sender keeps offering so the block backs up
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && words_checked >= 200) begin
            hold_left = 400;
            hold_done = 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                sink_mode = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (sink_mode)
                SINK_FREE:     i_out_ready <= 1'b1;
                SINK_MOSTLY:   i_out_ready <= ($urandom_range(0, 3) != 0);
                SINK_SPARSE:   i_out_ready <= ($urandom_range(0, 3) == 0);
                SINK_PERIODIC: i_out_ready <= ((mode_left % 5) == 0);
                default:       i_out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_checked++;
            if (o_end_of_stream === 1'b1)
                eos_seen++;
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $error("unexpected word: out_byte %0h with nothing pending", o_out_byte);
            end else begin
                want = expected_words.pop_front();
                if (o_out_byte !== want.data) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("out_byte mismatch: expected %0h, actual %0h",
                               want.data, o_out_byte);
                end
                if (o_last_of_run !== want.last) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("last_of_run mismatch: expected %0b, actual %0b",
                               want.last, o_last_of_run);
                end
                if (o_end_of_stream !== want.eos) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $error("end_of_stream mismatch: expected %0b, actual %0b",
                               want.eos, o_end_of_stream);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still pending",
                     cycle_count, expected_words.size());
            $display("block_framed_lzss_decoder_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // sender pauses until the block has nothing left to deliver or finish
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_in_valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // only called while idle
    task automatic write_out_len(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        out_len_m  = value;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        i_cfg_data = $urandom;
    endtask

    // one block: header plus body; mostly well-formed compressed items, with
    // raw blocks, empty blocks and random-body blocks mixed in; the body is
    // cut at the header length, so items are often cut short at block end
    task automatic queue_block(output int n_items);
        logic [7:0]  body [$];
        logic [7:0]  flag;
        logic [11:0] pos;
        logic [3:0]  len_field;
        logic        raw;
        int          len;
        int          kind;
        kind = $urandom_range(0, 19);
        len  = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        raw  = (kind >= 1 && kind <= 4);
        if (kind == 0) begin
            len = 0;
            raw = 1'($urandom_range(0, 1));
        end
        while (body.size() < len) begin
            if (raw || kind <= 7) begin
                body.push_back(8'($urandom));
            end else begin
                flag = 8'($urandom);
                body.push_back(flag);
                for (int i = 0; i < 8; i++) begin
                    if (flag[i]) begin
                        body.push_back(8'($urandom));
                    end else begin
                        // half near the restart point, where the recent bytes sit
                        if ($urandom_range(0, 1))
                            pos = RING_START + 12'($urandom_range(0, 80));
                        else
                            pos = 12'($urandom);
                        len_field = 4'($urandom_range(0, 15));
                        body.push_back(pos[7:0]);
                        body.push_back({pos[11:8], len_field});
                    end
                end
            end
        end
        while (body.size() > len)
            void'(body.pop_back());
        if (raw)
            raw_blocks++;
        else
            packed_blocks++;
        pending_bytes.push_back({raw, 7'(len >> 8)});
        pending_bytes.push_back(8'(len));
        foreach (body[i])
            pending_bytes.push_back(body[i]);
        n_items = len + 2;
    endtask

    task automatic queue_random(input int target);
        int got;
        int n;
        got = 0;
        while (got < target) begin
            queue_block(n);
            got += n;
        end
    endtask

    initial begin
        logic [7:0]  opening [24];
        logic [7:0]  zero_len [5];
        logic [31:0] lengths [6];

        // raw block; literal then an overlapping 18-byte match; a short match;
        // lone match first byte; empty block; lone flags (literal, match); empty raw
        opening = '{
            8'h80, 8'h03, 8'h00, 8'hFF, 8'h5A,
            8'h00, 8'h07, 8'h01, 8'h41, 8'hEE, 8'hFF, 8'hFF, 8'hF0, 8'h7B,
            8'h00, 8'h00,
            8'h00, 8'h01, 8'hFF,
            8'h00, 8'h01, 8'h00,
            8'h80, 8'h00
        };
        // with output_length zero: empty block ends the stream silently, then one raw byte
        zero_len = '{8'h00, 8'h00, 8'h80, 8'h01, 8'hA5};

        restart_ring();
        phase_m     = HDR_HI;
        remaining_m = '0;
        raw_m       = 1'b0;
        hdr_hi_m    = '0;
        match_lo_m  = '0;
        count_m     = '0;
        out_len_m   = 32'd1;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, reset value of output_length
        foreach (opening[i])
            pending_bytes.push_back(opening[i]);
        wait_drained();

        write_out_len(32'd0);
        foreach (zero_len[i])
            pending_bytes.push_back(zero_len[i]);
        wait_drained();

        // random part across several output_length settings, extremes included
        lengths = '{32'd1, 32'hFFFF_FFFF, 32'($urandom_range(20, 200)), 32'd0,
                    32'($urandom_range(500, 3000)), 32'd1};
        foreach (lengths[p]) begin
            write_out_len(lengths[p]);
            if (p == 2) begin
                queue_random(PHASE_ITEMS / 2);
                wait_drained();
                queue_random(PHASE_ITEMS / 2);
            end else begin
                queue_random(PHASE_ITEMS);
            end
            wait_drained();
        end

        $display("took %0d input words in %0d raw and %0d compressed random blocks",
                 items_taken, raw_blocks, packed_blocks);
        $display("checked %0d decoded words, %0d stream ends, %0d mismatches",
                 words_checked, eos_seen, fail_count);
        if (fail_count == 0)
            $display("block_framed_lzss_decoder_top verification clean");
        else
            $display("block_framed_lzss_decoder_top verification failed");
        $finish;
    end

endmodule

[files.f]
design/bfld_pkg.sv
design/bfld_ring.sv
design/block_framed_lzss_decoder_top.sv
bench/block_framed_lzss_decoder_top_tb.sv
